@@ sv/frame_pacer_rate_meter_assert.svh @@
// Assertion macros for the frame pacer and rate meter.
`ifndef FRAME_PACER_RATE_METER_ASSERT_SVH
`define FRAME_PACER_RATE_METER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fprm_pkg.sv @@
// Shared constants and types for the frame pacer and rate meter.
package fprm_pkg;

    localparam int WINDOW_FRAMES = 10;
    localparam int IDX_W         = $clog2(WINDOW_FRAMES);
    localparam int TIME_W        = 32;
    localparam int RATE_W        = 16;
    localparam int STEP_W        = 6;
    localparam int WAIT_W        = 16;
    localparam int RATE_NUM      = 1000 * WINDOW_FRAMES;
    localparam int NUM_W         = $clog2(RATE_NUM + 1);
    localparam int CNT_W         = $clog2(NUM_W + 1);

    localparam logic [RATE_W-1:0] RATE_MAX   = '1;
    localparam logic [STEP_W-1:0] STEP_CLAMP = STEP_W'(50);
    localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(16);

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ sv/fprm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/fprm_div.sv @@
// Bit-serial restoring divider: fixed rate numerator over a 32-bit span.
module fprm_div
    import fprm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } t_dstate;

    t_dstate           r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvs;
    logic [TIME_W-1:0] r_rem;
    logic [NUM_W-1:0]  r_quot;
    logic              r_done;

    logic [TIME_W:0]   trial;
    logic              fits;
    logic [TIME_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_dvs   <= i_req.divisor;
                        r_rem   <= '0;
                        r_quot  <= NUM_W'(RATE_NUM);
                        r_cnt   <= CNT_W'(NUM_W);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // one quotient bit per cycle, MSB first
                    r_rem  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
                    r_quot <= {r_quot[NUM_W-2:0], fits};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state == D_RUN);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ sv/frame_pacer_rate_meter.sv @@
// Frame pacer and moving-window frame rate meter, top level.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  poll in  | i_in_valid / o_in_stall     | i_now_msec
//  result   | o_out_valid / i_out_stall   | o_accepted o_frame_rate o_span_zero
//           |                             | o_delta_msec o_step_msec
//  config   | i_cfg_we                    | i_cfg_wdata (wait_msec)
//
// A rejected poll goes from accept through S_RDNEW and S_DONE to the result; an
// accepted one also passes S_RDOLD and waits in S_DIV for the serial divider, or
// skips S_DIV when the window span is zero and the divider is not started.
// Two window reads go through the single read port of the timestamp RAM.
// Reset is synchronous; per-entry valid bits make unwritten slots read as zero.
// A stalled result is held; the next poll is taken while it waits.
module frame_pacer_rate_meter
    import fprm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WAIT_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TIME_W-1:0] i_now_msec,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [RATE_W-1:0] o_frame_rate,
    output logic              o_span_zero,
    output logic [TIME_W-1:0] o_delta_msec,
    output logic [STEP_W-1:0] o_step_msec
);

    `include "frame_pacer_rate_meter_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDNEW,
        S_RDOLD,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WAIT_W-1:0]    r_wait;
    logic [TIME_W-1:0]    r_now;
    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_newest;
    logic [WINDOW_FRAMES-1:0] r_vld;
    logic [RATE_W-1:0]    r_rate;
    logic                 r_acc;
    logic                 r_zero;
    logic [TIME_W-1:0]    r_delta;
    logic [STEP_W-1:0]    r_step;

    logic                 in_take;
    logic [IDX_W-1:0]     rd_sel;
    logic [IDX_W-1:0]     ram_raddr;
    logic [TIME_W-1:0]    ram_rdata;
    logic [TIME_W-1:0]    stamp;
    logic [TIME_W-1:0]    diff;
    logic                 ram_we;
    logic [IDX_W-1:0]     n_head;
    logic [TIME_W-1:0]    q_ext;
    logic [RATE_W-1:0]    q_rate;
    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        // read newest on accept, oldest while checking the newest
        ram_raddr = (r_state == S_RDNEW) ? r_head : r_newest;
        rd_sel    = (r_state == S_RDOLD) ? r_head : r_newest;
        stamp     = r_vld[rd_sel] ? ram_rdata : '0;
        // shared subtractor: elapsed time, then window span
        diff      = r_now - stamp;
        ram_we    = (r_state == S_RDOLD);
        n_head    = (r_head == IDX_W'(WINDOW_FRAMES - 1)) ? '0 : r_head + IDX_W'(1);
        div_req.start   = (r_state == S_RDOLD) && (diff != '0);
        div_req.divisor = diff;
        q_ext  = TIME_W'(div_rsp.quot);
        q_rate = (q_ext > TIME_W'(RATE_MAX)) ? RATE_MAX : q_ext[RATE_W-1:0];
    end

    fprm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (WINDOW_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fprm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait      <= WAIT_RESET;
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_newest    <= IDX_W'(WINDOW_FRAMES - 1);
            r_vld       <= '0;
            r_rate      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wait <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!o_out_valid || !i_out_stall)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_now   <= i_now_msec;
                        r_state <= S_RDNEW;
                    end
                end
                S_RDNEW: begin
                    r_delta <= (stamp == '0) ? '0 : diff;
                    r_step  <= (stamp == '0) ? '0 :
                               (diff > TIME_W'(STEP_CLAMP)) ? STEP_CLAMP : diff[STEP_W-1:0];
                    r_zero  <= 1'b0;
                    if (diff >= TIME_W'(r_wait)) begin
                        r_acc   <= 1'b1;
                        r_state <= S_RDOLD;
                    end else begin
                        r_acc   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_RDOLD: begin
                    // record the frame over the oldest slot and advance
                    r_vld[r_head] <= 1'b1;
                    r_newest      <= r_head;
                    r_head        <= n_head;
                    if (diff == '0) begin
                        r_rate  <= RATE_MAX;
                        r_zero  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_rate  <= q_rate;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload, loaded only when the output slot is free
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!o_out_valid || !i_out_stall)) begin
            o_accepted   <= r_acc;
            o_frame_rate <= r_rate;
            o_span_zero  <= r_zero;
            o_delta_msec <= r_delta;
            o_step_msec  <= r_step;
        end
    end

    `FPRM_ASSERT_NXT(a_take_starts_read, in_take, r_state == S_RDNEW,
        "accepted poll did not start the window read")
    `FPRM_ASSERT_IMP(a_div_done_in_div, div_rsp.done, r_state == S_DIV,
        "divider finished outside the divide step")
    `FPRM_ASSERT_IMP(a_zero_needs_acc, o_out_valid && o_span_zero, o_accepted,
        "zero span flagged on a rejected poll")
    `FPRM_ASSERT_IMP(a_step_clamped, o_out_valid, o_step_msec <= STEP_CLAMP,
        "step exceeds clamp")
    `FPRM_ASSERT_IMP(a_div_busy_state, div_rsp.busy, r_state == S_DIV,
        "divider running outside the divide step")

endmodule
